[rtl/swt_pkg.sv]
// Shared types and constants for the shell word tokenizer.
`default_nettype none

package swt_pkg;

  localparam int SWT_MAX_PAREN_NEST = 15;
  localparam int SWT_MAX_RES        = 3;
  localparam int SWT_CNT_W          = $clog2(SWT_MAX_RES + 1);

  localparam logic [7:0] SWT_TOK_SLOTS_RST = 8'd16;

  // Configuration register byte addresses
  localparam logic [1:0] REG_TOK_SLOTS = 2'd0;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_BSL    = 8'h5c;
  localparam logic [7:0] CH_BTICK  = 8'h60;

  // One result word
  typedef struct packed {
    logic       has_char;
    logic [7:0] out_byte;
    logic       token_begin;
    logic       token_end;
    logic       literal_only;
    logic [7:0] word_total;
    logic       line_done;
    logic       last;
  } swt_res_t;

endpackage

`default_nettype wire

[rtl/shell_word_tokenizer_core.sv]
// Top level of the shell word tokenizer: register port, scanner and result buffer.
//
// Feed a command line one byte per word on the in_ channel; a word with
// in_end_of_line set closes the line (its in_byte is ignored). Results come
// out on the out_ channel: word bytes with begin/end marks, a literal-only
// flag on the end mark, the running word count, and out_last on the final
// result of each input word; out_line_done marks the end-of-line result.
// Latency: the first result of a byte is valid the cycle after it is taken.
// Throughput: one byte per cycle while each byte gives at most one result
// and out_ready is high; a byte that gives n results holds in_ready low
// until its last result is leaving the single result port.
// Bytes giving no result (blanks, quotes, comment text) pass at one a cycle.
// Reset (rst_n low at a clock edge) clears the scanner and the result
// register and sets the token-slot limit to 16. A stalled out_ready holds the
// current result; no further byte is taken until its last result is leaving.
// Write the token-slot limit (byte address 0) only while the block is idle.
`default_nettype none

module shell_word_tokenizer_core import swt_pkg::*; #(
  parameter int MAX_PAREN_NEST = SWT_MAX_PAREN_NEST
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_end_of_line,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_has_char,
  output logic [7:0]       out_byte,
  output logic             out_token_begin,
  output logic             out_token_end,
  output logic             out_literal_only,
  output logic [7:0]       out_word_total,
  output logic             out_line_done,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic                       take;
  logic                       can_load;
  logic [7:0]                 tok_slots_r;
  swt_res_t [SWT_MAX_RES-1:0] res_list;
  logic     [SWT_CNT_W-1:0]   res_cnt;
  swt_res_t                   out_res;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_TOK_SLOTS);
  assign prdata = (paddr == REG_TOK_SLOTS) ? {24'd0, tok_slots_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_slots_r <= SWT_TOK_SLOTS_RST;
    end else if (cfg_wr) begin
      tok_slots_r <= pwdata[7:0];
    end
  end

  assign in_ready = can_load;
  assign take     = in_valid && in_ready;

  swt_scan #(
    .MAX_PAREN_NEST (MAX_PAREN_NEST)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .in_byte    (in_byte),
    .in_eol     (in_end_of_line),
    .tok_slots  (tok_slots_r),
    .res_list   (res_list),
    .res_cnt    (res_cnt)
  );

  swt_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .load_list (res_list),
    .load_cnt  (res_cnt),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res),
    .can_load  (can_load)
  );

  assign out_has_char     = out_res.has_char;
  assign out_byte         = out_res.out_byte;
  assign out_token_begin  = out_res.token_begin;
  assign out_token_end    = out_res.token_end;
  assign out_literal_only = out_res.literal_only;
  assign out_word_total   = out_res.word_total;
  assign out_line_done    = out_res.line_done;
  assign out_last         = out_res.last;

`ifndef SYNTHESIS
  a_eol_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_end_of_line) |=> out_valid)
    else $error("end-of-line word produced no result");

  a_line_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_line_done) |-> out_last)
    else $error("line_done result is not the last of its byte");

  a_literal_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_literal_only) |-> (out_token_end && !out_has_char))
    else $error("literal_only outside a word end");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && !out_last) |-> !in_ready)
    else $error("input taken while a multi-result byte is still draining");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (tok_slots_r == $past(pwdata[7:0])))
    else $error("token-slot write lost");
`endif

endmodule

`default_nettype wire

[rtl/swt_scan.sv]
// Scanner state and per-byte result generation.
`default_nettype none

module swt_scan import swt_pkg::*; #(
  parameter int MAX_PAREN_NEST = SWT_MAX_PAREN_NEST
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          take,
  input  wire logic [7:0]                    in_byte,
  input  wire logic                          in_eol,
  input  wire logic [7:0]                    tok_slots,
  output swt_res_t [SWT_MAX_RES-1:0]         res_list,
  output logic     [SWT_CNT_W-1:0]           res_cnt
);

  localparam int PW = $clog2(MAX_PAREN_NEST + 1);

  typedef enum logic [2:0] {
    MODE_BETWEEN = 3'b001,
    MODE_WORD    = 3'b010,
    MODE_SKIP    = 3'b100
  } mode_t;

  typedef enum logic [1:0] {
    QK_NONE   = 2'd0,
    QK_SINGLE = 2'd1,
    QK_DOUBLE = 2'd2
  } qk_t;

  typedef enum logic [1:0] {
    PD_NONE   = 2'd0,
    PD_DOLLAR = 2'd1,
    PD_BSL    = 2'd2,
    PD_DQ_BSL = 2'd3
  } pd_t;

  mode_t           mode_r, mode_nxt;
  qk_t             qk_r, qk_nxt;
  logic [PW-1:0]   pn_r, pn_nxt;
  logic            bq_r, bq_nxt;
  pd_t             pd_r, pd_nxt;
  logic            ssq_r, ssq_nxt;
  logic            sexp_r, sexp_nxt;
  logic [7:0]      wk_r, wk_nxt;

  swt_res_t [SWT_MAX_RES-1:0] res_v;
  logic [SWT_CNT_W-1:0]       cnt_v;
  logic                       begin_due;
  logic                       do_wb;
  logic [7:0]                 limit;
  logic [7:0]                 c;

  function automatic swt_res_t mk_res(input logic has, input logic [7:0] ch,
                                      input logic beg, input logic fin,
                                      input logic lit, input logic [7:0] tot);
    swt_res_t r;
    r.has_char     = has;
    r.out_byte     = has ? ch : 8'd0;
    r.token_begin  = beg;
    r.token_end    = fin;
    r.literal_only = lit;
    r.word_total   = tot;
    r.line_done    = 1'b0;
    r.last         = 1'b0;
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_CR);
  endfunction

  assign c     = in_byte;
  assign limit = (tok_slots == 8'd0) ? 8'd0 : tok_slots - 8'd1;

  always_comb begin
    mode_nxt  = mode_r;
    qk_nxt    = qk_r;
    pn_nxt    = pn_r;
    bq_nxt    = bq_r;
    pd_nxt    = pd_r;
    ssq_nxt   = ssq_r;
    sexp_nxt  = sexp_r;
    wk_nxt    = wk_r;
    res_v     = '0;
    cnt_v     = '0;
    begin_due = 1'b0;
    do_wb     = 1'b0;

    if (in_eol) begin
      if (mode_r == MODE_WORD) begin
        // flush a held '$' or backslash as a plain byte
        unique case (pd_r)
          PD_DOLLAR, PD_BSL: begin
            sexp_nxt = 1'b1;
            res_v[cnt_v] = mk_res(1'b1, (pd_r == PD_DOLLAR) ? CH_DOLLAR : CH_BSL,
                                  1'b0, 1'b0, 1'b0, wk_nxt);
            cnt_v = cnt_v + 1'b1;
          end
          PD_DQ_BSL: begin
            res_v[cnt_v] = mk_res(1'b1, CH_BSL, 1'b0, 1'b0, 1'b0, wk_nxt);
            cnt_v = cnt_v + 1'b1;
          end
          default: ;
        endcase
        wk_nxt = wk_nxt + 8'd1;
        res_v[cnt_v] = mk_res(1'b0, 8'd0, 1'b0, 1'b1, ssq_nxt && !sexp_nxt, wk_nxt);
        cnt_v = cnt_v + 1'b1;
      end else begin
        res_v[cnt_v] = mk_res(1'b0, 8'd0, 1'b0, 1'b0, 1'b0, wk_nxt);
        cnt_v = cnt_v + 1'b1;
      end
      res_v[cnt_v - 1'b1].line_done = 1'b1;
      mode_nxt = MODE_BETWEEN;
      qk_nxt   = QK_NONE;
      pn_nxt   = '0;
      bq_nxt   = 1'b0;
      pd_nxt   = PD_NONE;
      ssq_nxt  = 1'b0;
      sexp_nxt = 1'b0;
      wk_nxt   = 8'd0;
    end else begin
      unique case (mode_r)
        MODE_WORD: begin
          if (pd_r != PD_NONE) begin
            pd_nxt = PD_NONE;
            unique case (pd_r)
              PD_DOLLAR: begin
                sexp_nxt = 1'b1;
                res_v[cnt_v] = mk_res(1'b1, CH_DOLLAR, 1'b0, 1'b0, 1'b0, wk_nxt);
                cnt_v = cnt_v + 1'b1;
                if (c == CH_LPAREN) begin
                  res_v[cnt_v] = mk_res(1'b1, CH_LPAREN, 1'b0, 1'b0, 1'b0, wk_nxt);
                  cnt_v = cnt_v + 1'b1;
                  pn_nxt = PW'(1);
                end else begin
                  do_wb = 1'b1;
                end
              end
              PD_BSL: begin
                sexp_nxt = 1'b1;
                // keep the backslash ahead of '$' and '`'
                if ((c == CH_DOLLAR) || (c == CH_BTICK)) begin
                  res_v[cnt_v] = mk_res(1'b1, CH_BSL, 1'b0, 1'b0, 1'b0, wk_nxt);
                  cnt_v = cnt_v + 1'b1;
                end
                res_v[cnt_v] = mk_res(1'b1, c, 1'b0, 1'b0, 1'b0, wk_nxt);
                cnt_v = cnt_v + 1'b1;
              end
              default: begin
                if ((c == CH_DQUOTE) || (c == CH_BSL)) begin
                  res_v[cnt_v] = mk_res(1'b1, c, 1'b0, 1'b0, 1'b0, wk_nxt);
                  cnt_v = cnt_v + 1'b1;
                end else begin
                  res_v[cnt_v] = mk_res(1'b1, CH_BSL, 1'b0, 1'b0, 1'b0, wk_nxt);
                  cnt_v = cnt_v + 1'b1;
                  do_wb = 1'b1;
                end
              end
            endcase
          end else begin
            do_wb = 1'b1;
          end
        end
        MODE_BETWEEN: begin
          if (!is_space(c)) begin
            if ((c == CH_HASH) || (wk_r >= limit)) begin
              mode_nxt = MODE_SKIP;
            end else begin
              mode_nxt  = MODE_WORD;
              begin_due = 1'b1;
              do_wb     = 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (do_wb) begin
        if (qk_nxt == QK_SINGLE) begin
          if (c == CH_SQUOTE) begin
            qk_nxt = QK_NONE;
          end else begin
            res_v[cnt_v] = mk_res(1'b1, c, begin_due, 1'b0, 1'b0, wk_nxt);
            begin_due = 1'b0;
            cnt_v = cnt_v + 1'b1;
          end
        end else if (qk_nxt == QK_DOUBLE) begin
          if (c == CH_DQUOTE) begin
            qk_nxt = QK_NONE;
          end else if (c == CH_BSL) begin
            pd_nxt = PD_DQ_BSL;
          end else begin
            res_v[cnt_v] = mk_res(1'b1, c, begin_due, 1'b0, 1'b0, wk_nxt);
            begin_due = 1'b0;
            cnt_v = cnt_v + 1'b1;
          end
        end else if (pn_nxt != '0) begin
          // inside $( ... ): track depth, saturate at the top
          if (c == CH_LPAREN) begin
            if (pn_nxt < PW'(MAX_PAREN_NEST)) begin
              pn_nxt = pn_nxt + 1'b1;
            end
          end else if (c == CH_RPAREN) begin
            pn_nxt = pn_nxt - 1'b1;
          end
          res_v[cnt_v] = mk_res(1'b1, c, begin_due, 1'b0, 1'b0, wk_nxt);
          begin_due = 1'b0;
          cnt_v = cnt_v + 1'b1;
        end else if (bq_nxt) begin
          if (c == CH_BTICK) begin
            bq_nxt = 1'b0;
          end
          res_v[cnt_v] = mk_res(1'b1, c, begin_due, 1'b0, 1'b0, wk_nxt);
          begin_due = 1'b0;
          cnt_v = cnt_v + 1'b1;
        end else if (c == CH_DOLLAR) begin
          pd_nxt = PD_DOLLAR;
        end else if (c == CH_BTICK) begin
          bq_nxt   = 1'b1;
          sexp_nxt = 1'b1;
          res_v[cnt_v] = mk_res(1'b1, c, begin_due, 1'b0, 1'b0, wk_nxt);
          begin_due = 1'b0;
          cnt_v = cnt_v + 1'b1;
        end else if (c == CH_SQUOTE) begin
          qk_nxt  = QK_SINGLE;
          ssq_nxt = 1'b1;
        end else if (c == CH_DQUOTE) begin
          qk_nxt   = QK_DOUBLE;
          sexp_nxt = 1'b1;
        end else if (c == CH_BSL) begin
          pd_nxt = PD_BSL;
        end else if (is_space(c)) begin
          // close the word and keep it
          wk_nxt = wk_nxt + 8'd1;
          res_v[cnt_v] = mk_res(1'b0, 8'd0, begin_due, 1'b1, ssq_nxt && !sexp_nxt,
                                wk_nxt);
          begin_due = 1'b0;
          cnt_v = cnt_v + 1'b1;
          mode_nxt = MODE_BETWEEN;
          qk_nxt   = QK_NONE;
          pn_nxt   = '0;
          bq_nxt   = 1'b0;
          pd_nxt   = PD_NONE;
          ssq_nxt  = 1'b0;
          sexp_nxt = 1'b0;
        end else begin
          sexp_nxt = 1'b1;
          res_v[cnt_v] = mk_res(1'b1, c, begin_due, 1'b0, 1'b0, wk_nxt);
          begin_due = 1'b0;
          cnt_v = cnt_v + 1'b1;
        end
      end

      // word opened with nothing to show yet
      if (begin_due) begin
        res_v[cnt_v] = mk_res(1'b0, 8'd0, 1'b1, 1'b0, 1'b0, wk_nxt);
        cnt_v = cnt_v + 1'b1;
      end
    end

    if (cnt_v != '0) begin
      res_v[cnt_v - 1'b1].last = 1'b1;
    end
  end

  assign res_list = res_v;
  assign res_cnt  = cnt_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BETWEEN;
      qk_r   <= QK_NONE;
      pn_r   <= '0;
      bq_r   <= 1'b0;
      pd_r   <= PD_NONE;
      ssq_r  <= 1'b0;
      sexp_r <= 1'b0;
      wk_r   <= 8'd0;
    end else if (take) begin
      mode_r <= mode_nxt;
      qk_r   <= qk_nxt;
      pn_r   <= pn_nxt;
      bq_r   <= bq_nxt;
      pd_r   <= pd_nxt;
      ssq_r  <= ssq_nxt;
      sexp_r <= sexp_nxt;
      wk_r   <= wk_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/swt_outbuf.sv]
// Result register: holds the words of one byte and drains them in order.
`default_nettype none

module swt_outbuf import swt_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire swt_res_t [SWT_MAX_RES-1:0]    load_list,
  input  wire logic     [SWT_CNT_W-1:0]      load_cnt,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output swt_res_t                           out_res,
  output logic                               can_load
);

  swt_res_t [SWT_MAX_RES-1:0] q_r;
  logic     [SWT_CNT_W-1:0]   cnt_r;
  logic                       pop;

  assign out_valid = (cnt_r != '0);
  assign out_res   = q_r[0];
  assign pop       = out_valid && out_ready;
  // take a new batch when empty or when the last held word leaves now
  assign can_load  = (cnt_r == '0) || ((cnt_r == SWT_CNT_W'(1)) && out_ready);

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= load_list;
    end else if (pop) begin
      for (int i = 0; i < SWT_MAX_RES - 1; i++) begin
        q_r[i] <= q_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= load_cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

`default_nettype wire
